// ===== rtl/lcpm_pkg.sv =====
// ----------------------------------------------------------------------------
// lcpm_pkg
// Shared types, sizes and codes for the lamp channel presence monitor.
// ----------------------------------------------------------------------------
package lcpm_pkg;

  // Block sizes
  localparam int RING_DEPTH       = 30;
  localparam int CURRENT_CHANNELS = 8;
  localparam int SENSE_PINS       = 9;
  localparam int COUNT_WIDTH      = 32;

  // Fixed field widths of the ports
  localparam int ADC_W       = 10;
  localparam int PORT_CHANS  = 8;
  localparam int PIN_PORT_W  = 9;
  localparam int VOLT_W      = 8;
  localparam int DEC_W       = 4;
  localparam int THR_W       = 10;
  localparam int RATIO_W     = 7;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int OP_W        = 2;

  // Derived sizes
  localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W  = ADC_W + $clog2(RING_DEPTH);
  localparam int PROD_W = COUNT_WIDTH + RATIO_W;

  // Result queue
  localparam int OUT_DEPTH = 4;
  localparam int OQ_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OQ_CNT_W  = $clog2(OUT_DEPTH + 1);

  // Decimal weight on the high-level count of the pin activity test
  localparam int HIGH_WEIGHT = 100;

  typedef enum logic [OP_W-1:0] {
    OP_FRAME = 2'd0,
    OP_PINS  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECIMATION = 2'd0,
    CFG_THRESHOLD  = 2'd1,
    CFG_RATIO      = 2'd2
  } cfg_idx_t;

  typedef logic [CURRENT_CHANNELS-1:0][ADC_W-1:0] frame_t;
  typedef logic [CURRENT_CHANNELS-1:0][SUM_W-1:0] sum_vec_t;
  typedef logic [SENSE_PINS-1:0][COUNT_WIDTH-1:0] cnt_vec_t;

  typedef struct packed {
    logic [CURRENT_CHANNELS > 0 ? 7 : 7:0] current_present;
    logic [VOLT_W-1:0]                     voltage_active;
    logic                                  mains_active;
  } status_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } status_push_t;

endpackage

// ===== rtl/lcpm_status.sv =====
// ----------------------------------------------------------------------------
// lcpm_status
// Presence tests: channel sums against the scaled threshold, and the
// weighted low/high level count test for every sense pin.
// ----------------------------------------------------------------------------
module lcpm_status
  import lcpm_pkg::*;
(
  input  sum_vec_t            sums,
  input  cnt_vec_t            high_counts,
  input  cnt_vec_t            low_counts,
  input  logic [THR_W-1:0]    threshold,
  input  logic [RATIO_W-1:0]  ratio_percent,
  output status_t             status
);

  logic [SUM_W-1:0]      thr_scaled;
  logic [SENSE_PINS-1:0] pin_act;
  logic [7:0]            cur;
  logic [VOLT_W-1:0]     volt;

  // The average is below the threshold exactly when sum < threshold * depth.
  assign thr_scaled = SUM_W'(threshold) * SUM_W'(RING_DEPTH);

  for (genvar c = 0; c < 8; c++) begin : g_cur
    if (c < CURRENT_CHANNELS) begin : g_used
      assign cur[c] = (sums[c] < thr_scaled);
    end else begin : g_unused
      assign cur[c] = 1'b0;
    end
  end

  for (genvar p = 0; p < SENSE_PINS; p++) begin : g_pin
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;
    assign lhs        = PROD_W'(ratio_percent) * PROD_W'(low_counts[p]);
    assign rhs        = PROD_W'(HIGH_WEIGHT) * PROD_W'(high_counts[p]);
    assign pin_act[p] = (lhs > rhs);
  end

  for (genvar v = 0; v < VOLT_W; v++) begin : g_volt
    if (v + 1 < SENSE_PINS) begin : g_used
      assign volt[v] = pin_act[v];
    end else begin : g_unused
      assign volt[v] = 1'b0;
    end
  end

  assign status.current_present = cur;
  assign status.voltage_active  = volt;
  assign status.mains_active    = pin_act[SENSE_PINS-1];

endmodule

// ===== rtl/lcpm_out_fifo.sv =====
// ----------------------------------------------------------------------------
// lcpm_out_fifo
// Small result queue in front of the output channel.
// ----------------------------------------------------------------------------
module lcpm_out_fifo
  import lcpm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  status_push_t        push,
  input  logic                out_stall,
  output logic                out_valid,
  output status_t             out_status,
  output logic [OQ_CNT_W-1:0] count
);

  status_t             mem_r [OUT_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_r;
  logic [OQ_PTR_W-1:0] rd_ptr_r;
  logic [OQ_CNT_W-1:0] cnt_r;
  logic [OQ_CNT_W-1:0] cnt_nxt;
  logic                pop;

  assign out_valid  = (cnt_r != '0);
  assign out_status = mem_r[rd_ptr_r];
  assign pop        = out_valid && !out_stall;
  assign count      = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !pop) begin
      cnt_nxt = cnt_r + OQ_CNT_W'(1);
    end else if (!push.valid && pop) begin
      cnt_nxt = cnt_r - OQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + OQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OQ_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.status;
    end
  end

endmodule

// ===== rtl/lamp_channel_presence_monitor.sv =====
// ----------------------------------------------------------------------------
// lamp_channel_presence_monitor
// Current and voltage presence monitor: moving average of decimated ADC
// frames per current channel, and saturating level counters per sense pin.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                   Direction   Handshake
//  input     in_op, in_sample_0..7, in_pin_levels    in          in_valid / in_stall
//  result    out_current_present, out_voltage_active out         out_valid / out_stall
//            out_mains_active
//  config    cfg_we, cfg_index, cfg_data             in          write enable only
//
// One item is taken per clock cycle while in_stall is low. An item is
// registered on acceptance, updates the ring, sums and pin counters in the
// next cycle, and its status is computed from the updated state while the
// item is in the second stage and written into a four-entry result queue.
// The input stalls only when items in flight plus queued results fill the
// queue, so out_stall reaches in_stall through registered state alone.
// Reset is synchronous and active low; the ring holds a valid bit per
// entry, so an entry not yet written reads as zero and no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module lamp_channel_presence_monitor
  import lcpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_op,
  input  logic [ADC_W-1:0]      in_sample_0,
  input  logic [ADC_W-1:0]      in_sample_1,
  input  logic [ADC_W-1:0]      in_sample_2,
  input  logic [ADC_W-1:0]      in_sample_3,
  input  logic [ADC_W-1:0]      in_sample_4,
  input  logic [ADC_W-1:0]      in_sample_5,
  input  logic [ADC_W-1:0]      in_sample_6,
  input  logic [ADC_W-1:0]      in_sample_7,
  input  logic [PIN_PORT_W-1:0] in_pin_levels,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_current_present,
  output logic [VOLT_W-1:0]     out_voltage_active,
  output logic                  out_mains_active,
  // Configuration port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [DEC_W-1:0]   dec_r;
  logic [THR_W-1:0]   thr_r;
  logic [RATIO_W-1:0] ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r   <= DEC_W'(1);
      thr_r   <= THR_W'(800);
      ratio_r <= RATIO_W'(95);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DECIMATION: dec_r   <= cfg_data[DEC_W-1:0];
        CFG_THRESHOLD:  thr_r   <= cfg_data[THR_W-1:0];
        CFG_RATIO:      ratio_r <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Flow control: every accepted item is guaranteed a place in the queue.
  logic [OQ_CNT_W-1:0] oq_count;
  logic [OQ_CNT_W-1:0] occupancy;
  logic                s1_v_r;
  logic                s2_v_r;
  logic                in_accept;

  assign occupancy = oq_count + OQ_CNT_W'(s1_v_r) + OQ_CNT_W'(s2_v_r);
  assign in_stall  = (occupancy >= OQ_CNT_W'(OUT_DEPTH));
  assign in_accept = in_valid && !in_stall;

  // Input register stage.
  logic [PORT_CHANS-1:0][ADC_W-1:0] in_samples;
  logic [OP_W-1:0]                  s1_op_r;
  frame_t                           s1_frame_r;
  logic [PIN_PORT_W-1:0]            s1_levels_r;

  assign in_samples = {in_sample_7, in_sample_6, in_sample_5, in_sample_4,
                       in_sample_3, in_sample_2, in_sample_1, in_sample_0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_accept;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r     <= in_op;
      s1_levels_r <= in_pin_levels;
      for (int c = 0; c < CURRENT_CHANNELS; c++) begin
        s1_frame_r[c] <= in_samples[c];
      end
    end
  end

  // State: sample ring with per-entry valid bits, running sums, pointers
  // and the pin level counters.
  frame_t                ring_r [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_vld_r;
  logic [PTR_W-1:0]      ptr_r;
  logic [PTR_W-1:0]      ptr_nxt;
  logic [DEC_W-1:0]      skip_r;
  logic [DEC_W-1:0]      skip_nxt;
  sum_vec_t              sum_r;
  sum_vec_t              sum_nxt;
  cnt_vec_t              high_r;
  cnt_vec_t              high_nxt;
  cnt_vec_t              low_r;
  cnt_vec_t              low_nxt;
  frame_t                old_frame;
  logic                  store;
  logic [SENSE_PINS-1:0] lvl;

  // An entry never written holds no sample and counts as zero.
  assign old_frame = ring_vld_r[ptr_r] ? ring_r[ptr_r] : '0;

  // Pins beyond the width of the level port read as low.
  for (genvar p = 0; p < SENSE_PINS; p++) begin : g_lvl
    if (p < PIN_PORT_W) begin : g_port
      assign lvl[p] = s1_levels_r[p];
    end else begin : g_none
      assign lvl[p] = 1'b0;
    end
  end

  always_comb begin
    store    = 1'b0;
    ptr_nxt  = ptr_r;
    skip_nxt = skip_r;
    sum_nxt  = sum_r;
    high_nxt = high_r;
    low_nxt  = low_r;
    if (s1_v_r) begin
      case (s1_op_r)
        OP_FRAME: begin
          if (skip_r >= dec_r) begin
            // Keep this frame: replace the oldest entry in the sums.
            store    = 1'b1;
            skip_nxt = '0;
            for (int c = 0; c < CURRENT_CHANNELS; c++) begin
              sum_nxt[c] = sum_r[c] - SUM_W'(old_frame[c]) + SUM_W'(s1_frame_r[c]);
            end
            if (ptr_r == PTR_W'(RING_DEPTH - 1)) begin
              ptr_nxt = '0;
            end else begin
              ptr_nxt = ptr_r + PTR_W'(1);
            end
          end else begin
            skip_nxt = skip_r + DEC_W'(1);
          end
        end
        OP_PINS: begin
          // Counters stop at all ones.
          for (int p = 0; p < SENSE_PINS; p++) begin
            if (lvl[p]) begin
              if (high_r[p] != '1) begin
                high_nxt[p] = high_r[p] + COUNT_WIDTH'(1);
              end
            end else begin
              if (low_r[p] != '1) begin
                low_nxt[p] = low_r[p] + COUNT_WIDTH'(1);
              end
            end
          end
        end
        OP_CLEAR: begin
          high_nxt = '0;
          low_nxt  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
      ptr_r      <= '0;
      skip_r     <= '0;
      sum_r      <= '0;
      high_r     <= '0;
      low_r      <= '0;
    end else begin
      ptr_r  <= ptr_nxt;
      skip_r <= skip_nxt;
      sum_r  <= sum_nxt;
      high_r <= high_nxt;
      low_r  <= low_nxt;
      if (store) begin
        ring_vld_r[ptr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      ring_r[ptr_r] <= s1_frame_r;
    end
  end

  // Status of the item in the second stage, taken from the updated state.
  status_t      status;
  status_push_t push;
  status_t      out_status;

  lcpm_status u_status (
    .sums          (sum_r),
    .high_counts   (high_r),
    .low_counts    (low_r),
    .threshold     (thr_r),
    .ratio_percent (ratio_r),
    .status        (status)
  );

  assign push.valid  = s2_v_r;
  assign push.status = status;

  lcpm_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_status (out_status),
    .count      (oq_count)
  );

  assign out_current_present = out_status.current_present;
  assign out_voltage_active  = out_status.voltage_active;
  assign out_mains_active    = out_status.mains_active;

  // Items in flight and queued results never exceed the queue depth.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= OQ_CNT_W'(OUT_DEPTH))
    else $error("result queue overcommitted");

  // The pipeline never holds an item back.
  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |=> s2_v_r)
    else $error("first stage item lost");

  // The ring pointer stays inside the ring.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PTR_W'(RING_DEPTH - 1))
    else $error("ring pointer out of range");

  // A stored frame restarts the skip count and advances the pointer.
  a_store_restart: assert property (@(posedge clk) disable iff (!rst_n)
    store |=> (skip_r == '0) && (ptr_r != $past(ptr_r)))
    else $error("stored frame did not restart decimation");

endmodule
